// ===== rtl/dwec_pkg.sv =====
// Shared constants and angle table for the delayed waypoint error checker.
package dwec_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int HOR_W = 26;
	localparam logic [HOR_W-1:0] HORIZON_RESET = 26'd1000000;
	localparam int IN_DATA_W = 240;
	localparam int OUT_DATA_W = 208;
	localparam int ENTRY_W = 192;
	localparam logic signed [35:0] CORDIC_K = 36'sd652032875;

	function automatic logic [15:0] yaw_tab(input logic [3:0] i);
		logic [15:0] t;
		case (i)
			4'd0: t = 16'd8192;
			4'd1: t = 16'd4836;
			4'd2: t = 16'd2555;
			4'd3: t = 16'd1297;
			4'd4: t = 16'd651;
			4'd5: t = 16'd326;
			4'd6: t = 16'd163;
			4'd7: t = 16'd81;
			4'd8: t = 16'd41;
			4'd9: t = 16'd20;
			4'd10: t = 16'd10;
			4'd11: t = 16'd5;
			4'd12: t = 16'd3;
			4'd13: t = 16'd1;
			4'd14: t = 16'd1;
			default: t = 16'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/delayed_waypoint_error_checker.sv =====
// Top level of the delayed waypoint error checker: queue memory, CORDIC and root sequencer.
//
// Input stream s_*: one transaction is an odometry sample (s_tuser = 0) or a
// waypoint prediction (s_tuser = 1). Waypoints are queued with the latest pose
// in a one-port synchronous memory; odometry samples update the pose and
// retire waypoints from the head while stamp plus horizon_time is reached.
// Output stream m_*: one transaction per retired waypoint, m_tlast marks the
// final one caused by a sample. A sample that retires nothing gives no output.
// cfg_we/cfg_wdata write horizon_time; write only while the block is idle.
// Processing: a waypoint is handled on acceptance. A sample first finds the yaw
// (setup, then 16 vectoring steps), then for each retired entry: memory read,
// 16 rotation steps, products on the shared multiplier and 32 square-root
// steps. These steps share the CORDIC datapath and the multiplier. If entries
// remain, one more memory read finds an entry not yet due and ends the loop.
// Reset clears the queue, the pose and the output register; horizon_time
// returns to 1000000. When the receiver stalls, the finished result waits in
// a holding register and the sequencer holds before loading the next one.
module delayed_waypoint_error_checker #(
	parameter int QUEUE_DEPTH = dwec_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// stamp, pos_x, pos_y, quat_w, quat_x, quat_y, quat_z, pred_x, pred_y
	input  logic [dwec_pkg::IN_DATA_W-1:0] s_tdata,
	// operation
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// entry_stamp, predicted_dx, predicted_dy, recorded_dx, recorded_dy,
	// error_distance, one zero pad bit
	output logic [dwec_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic m_tlast,
	input  logic cfg_we,
	input  logic [dwec_pkg::HOR_W-1:0] cfg_wdata
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_YMUL = 4'd1;
	localparam logic [3:0] S_YINIT = 4'd2;
	localparam logic [3:0] S_YAW = 4'd3;
	localparam logic [3:0] S_RD = 4'd4;
	localparam logic [3:0] S_CHK = 4'd5;
	localparam logic [3:0] S_ROT = 4'd6;
	localparam logic [3:0] S_MATH = 4'd7;
	localparam logic [3:0] S_SQRT = 4'd8;
	localparam logic [3:0] S_PUSH = 4'd9;
	localparam logic [3:0] S_FIN = 4'd10;

	logic [3:0] state_q;
	logic [dwec_pkg::HOR_W-1:0] horizon_q;
	logic [PW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [47:0] last_stamp_q;
	logic signed [31:0] last_x_q, last_y_q;
	logic [15:0] last_heading_q;
	logic pose_valid_q;

	logic [dwec_pkg::ENTRY_W-1:0] mem [QUEUE_DEPTH];
	logic [dwec_pkg::ENTRY_W-1:0] rd_q;
	logic [PW-1:0] wr_addr;
	logic [CW:0] wr_sum;

	logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
	logic signed [31:0] p_wz_q, p_xy_q, p_yy_q, p_zz_q;
	logic signed [35:0] zx_q, zy_q;
	logic signed [17:0] za_q;
	logic [15:0] ang_q;
	logic neg_q;
	logic [4:0] it_q;
	logic [3:0] ms_q;

	logic signed [33:0] c_q, s_q;
	logic signed [33:0] ma, mb;
	logic signed [67:0] prod_q, acc_x_q, acc_y_q;
	logic signed [37:0] rx_c, ry_c, rx_q, ry_q;
	logic signed [38:0] ex_c, ey_c;
	logic signed [33:0] ex_q, ey_q;
	logic big_q;
	logic [63:0] sq_v_q, sq_r_q, sq_b_q;
	logic [64:0] sq_t;

	logic [206:0] res_q, new_res;
	logic res_have_q;
	logic out_free;
	logic in_acc;

	logic [47:0] e_stamp;
	logic signed [31:0] e_x, e_y, e_px, e_py;
	logic [15:0] e_head;
	logic signed [32:0] dx, dy;
	logic [3:0] ti;
	logic [15:0] tab;

	logic signed [35:0] yn, yd;
	logic signed [17:0] ha;
	logic [30:0] err;
	logic [31:0] rdx_sat, rdy_sat;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	assign e_stamp = rd_q[47:0];
	assign e_x = rd_q[79:48];
	assign e_y = rd_q[111:80];
	assign e_head = rd_q[127:112];
	assign e_px = rd_q[159:128];
	assign e_py = rd_q[191:160];
	assign dx = 33'(last_x_q) - 33'(e_x);
	assign dy = 33'(last_y_q) - 33'(e_y);

	assign ti = it_q[3:0];
	assign tab = dwec_pkg::yaw_tab(ti);

	assign wr_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign wr_addr = (wr_sum >= (CW+1)'(QUEUE_DEPTH)) ?
		PW'(wr_sum - (CW+1)'(QUEUE_DEPTH)) : PW'(wr_sum);

	always_comb begin
		yn = 36'(2) * (36'(p_wz_q) + 36'(p_xy_q));
		yd = 36'sd268435456 - 36'(2) * (36'(p_yy_q) + 36'(p_zz_q));
		ha = 18'(signed'(e_head));
		if (ha > 18'sd16384) begin
			ha = ha - 18'sd32768;
		end else if (ha < -18'sd16384) begin
			ha = ha + 18'sd32768;
		end
	end

	always_comb begin
		unique case (ms_q)
			4'd0: begin ma = c_q; mb = 34'(dx); end
			4'd1: begin ma = s_q; mb = 34'(dy); end
			4'd2: begin ma = c_q; mb = 34'(dy); end
			4'd3: begin ma = s_q; mb = 34'(dx); end
			4'd7: begin ma = ex_q; mb = ex_q; end
			4'd8: begin ma = ey_q; mb = ey_q; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign rx_c = 38'((acc_x_q + 68'sd536870912) >>> 30);
	assign ry_c = 38'((acc_y_q + 68'sd536870912) >>> 30);
	assign ex_c = 39'(e_px) - 39'(rx_q);
	assign ey_c = 39'(e_py) - 39'(ry_q);
	assign sq_t = 65'(sq_r_q) + 65'(sq_b_q);

	always_comb begin
		if (rx_q > 38'sd2147483647) rdx_sat = 32'h7FFFFFFF;
		else if (rx_q < -38'sd2147483648) rdx_sat = 32'h80000000;
		else rdx_sat = rx_q[31:0];
		if (ry_q > 38'sd2147483647) rdy_sat = 32'h7FFFFFFF;
		else if (ry_q < -38'sd2147483648) rdy_sat = 32'h80000000;
		else rdy_sat = ry_q[31:0];
		if (big_q || sq_r_q > 64'h7FFFFFFF) err = 31'h7FFFFFFF;
		else err = sq_r_q[30:0];
		new_res = {err, rdy_sat, rdx_sat, e_py, e_px, e_stamp};
	end

	always_ff @(posedge clk) begin
		if (in_acc && s_tuser && pose_valid_q && count_q < DEPTH_C) begin
			mem[wr_addr] <= {s_tdata[239:176], last_heading_q, last_y_q, last_x_q,
				s_tdata[47:0]};
		end
		if (state_q == S_RD) begin
			rd_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			horizon_q <= dwec_pkg::HORIZON_RESET;
			head_q <= '0;
			count_q <= '0;
			last_stamp_q <= '0;
			last_x_q <= '0;
			last_y_q <= '0;
			last_heading_q <= '0;
			pose_valid_q <= 1'b0;
			res_have_q <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tlast <= 1'b0;
			it_q <= '0;
			ms_q <= '0;
		end else begin
			if (cfg_we) begin
				horizon_q <= cfg_wdata;
			end
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (s_tuser) begin
							if (pose_valid_q && count_q < DEPTH_C) begin
								count_q <= count_q + CW'(1);
							end
						end else begin
							if (pose_valid_q && s_tdata[47:0] < last_stamp_q) begin
								count_q <= '0;
								head_q <= '0;
							end
							last_stamp_q <= s_tdata[47:0];
							last_x_q <= s_tdata[79:48];
							last_y_q <= s_tdata[111:80];
							qw_q <= s_tdata[127:112];
							qx_q <= s_tdata[143:128];
							qy_q <= s_tdata[159:144];
							qz_q <= s_tdata[175:160];
							pose_valid_q <= 1'b1;
							state_q <= S_YMUL;
						end
					end
				end
				S_YMUL: begin
					p_wz_q <= qw_q * qz_q;
					p_xy_q <= qx_q * qy_q;
					p_yy_q <= qy_q * qy_q;
					p_zz_q <= qz_q * qz_q;
					state_q <= S_YINIT;
				end
				S_YINIT: begin
					neg_q <= (yn == 0 && yd == 0);
					if (yd < 0) begin
						zx_q <= -yd;
						zy_q <= -yn;
						ang_q <= 16'h8000;
					end else begin
						zx_q <= yd;
						zy_q <= yn;
						ang_q <= '0;
					end
					it_q <= '0;
					state_q <= S_YAW;
				end
				S_YAW: begin
					if (zy_q > 0) begin
						zx_q <= zx_q + (zy_q >>> ti);
						zy_q <= zy_q - (zx_q >>> ti);
						ang_q <= ang_q + tab;
					end else begin
						zx_q <= zx_q - (zy_q >>> ti);
						zy_q <= zy_q + (zx_q >>> ti);
						ang_q <= ang_q - tab;
					end
					it_q <= it_q + 5'd1;
					if (ti == 4'd15) begin
						last_heading_q <= neg_q ? 16'd0 :
							((zy_q > 0) ? ang_q + tab : ang_q - tab);
						state_q <= (count_q == '0) ? S_FIN : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if ({1'b0, last_stamp_q} >= {1'b0, e_stamp} + 49'(horizon_q)) begin
						zx_q <= dwec_pkg::CORDIC_K;
						zy_q <= '0;
						za_q <= ha;
						neg_q <= (signed'(e_head) > 16'sd16384) ||
							(signed'(e_head) < -16'sd16384);
						it_q <= '0;
						state_q <= S_ROT;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_ROT: begin
					if (za_q >= 0) begin
						zx_q <= zx_q - (zy_q >>> ti);
						zy_q <= zy_q + (zx_q >>> ti);
						za_q <= za_q - 18'(tab);
					end else begin
						zx_q <= zx_q + (zy_q >>> ti);
						zy_q <= zy_q - (zx_q >>> ti);
						za_q <= za_q + 18'(tab);
					end
					it_q <= it_q + 5'd1;
					if (ti == 4'd15) begin
						if (za_q >= 0) begin
							c_q <= neg_q ? -34'(zx_q - (zy_q >>> ti)) : 34'(zx_q - (zy_q >>> ti));
							s_q <= neg_q ? -34'(zy_q + (zx_q >>> ti)) : 34'(zy_q + (zx_q >>> ti));
						end else begin
							c_q <= neg_q ? -34'(zx_q + (zy_q >>> ti)) : 34'(zx_q + (zy_q >>> ti));
							s_q <= neg_q ? -34'(zy_q - (zx_q >>> ti)) : 34'(zy_q - (zx_q >>> ti));
						end
						ms_q <= '0;
						state_q <= S_MATH;
					end
				end
				S_MATH: begin
					ms_q <= ms_q + 4'd1;
					case (ms_q)
						4'd1: acc_x_q <= prod_q;
						4'd2: acc_x_q <= acc_x_q + prod_q;
						4'd3: acc_y_q <= prod_q;
						4'd4: acc_y_q <= acc_y_q - prod_q;
						4'd5: begin
							rx_q <= rx_c;
							ry_q <= ry_c;
						end
						4'd6: begin
							ex_q <= 34'(ex_c);
							ey_q <= 34'(ey_c);
							big_q <= (ex_c >= 39'sd2147483648) || (ex_c <= -39'sd2147483648) ||
								(ey_c >= 39'sd2147483648) || (ey_c <= -39'sd2147483648);
						end
						4'd8: sq_v_q <= 64'(prod_q);
						4'd9: begin
							sq_v_q <= sq_v_q + 64'(prod_q);
							sq_r_q <= '0;
							sq_b_q <= 64'h4000000000000000;
							it_q <= '0;
							state_q <= S_SQRT;
						end
						default: ;
					endcase
				end
				S_SQRT: begin
					if ({1'b0, sq_v_q} >= sq_t) begin
						sq_v_q <= sq_v_q - sq_t[63:0];
						sq_r_q <= (sq_r_q >> 1) + sq_b_q;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					sq_b_q <= sq_b_q >> 2;
					it_q <= it_q + 5'd1;
					if (it_q == 5'd31) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (!res_have_q || out_free) begin
						if (res_have_q) begin
							m_tvalid <= 1'b1;
							m_tdata <= {1'b0, res_q};
							m_tlast <= 1'b0;
						end
						res_q <= new_res;
						res_have_q <= 1'b1;
						head_q <= (head_q == LAST_PTR) ? '0 : head_q + PW'(1);
						count_q <= count_q - CW'(1);
						state_q <= (count_q == CW'(1)) ? S_FIN : S_RD;
					end
				end
				S_FIN: begin
					if (!res_have_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata <= {1'b0, res_q};
						m_tlast <= 1'b1;
						res_have_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/dwec_checker.sv =====
// Port-level assertions for the delayed waypoint error checker, bound to the top level.
module dwec_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [dwec_pkg::IN_DATA_W-1:0] s_tdata,
	input logic s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic [dwec_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[dwec_pkg::OUT_DATA_W-1] == 1'b0)
		else $error("output pad bit set");

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result loaded while input side idle");

	a_wp_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !$rose(m_tvalid))
		else $error("waypoint produced a result");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser && s_tdata[0] == s_tdata[0] |=> !s_tready)
		else $error("odometry sample not processed");

endmodule

bind delayed_waypoint_error_checker dwec_checker u_dwec_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata(s_tdata),
	.s_tuser(s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast)
);

// ===== test/tb_delayed_waypoint_error_checker.sv =====
// Self-checking testbench for the delayed waypoint error checker: directed table, then random traffic.
module tb_delayed_waypoint_error_checker;

	localparam int DEPTH = dwec_pkg::QUEUE_DEPTH_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 200;
	localparam int EXP_DEPTH = 256;
	localparam int MAX_ROWS = 32;
	localparam logic OP_ODOM = 1'b0;
	localparam logic OP_WAYPOINT = 1'b1;

	typedef struct {
		logic op;
		logic [47:0] stamp;
		logic signed [31:0] pos_x, pos_y;
		logic signed [15:0] qw, qx, qy, qz;
		logic signed [31:0] pred_x, pred_y;
	} sample_t;

	typedef struct {
		logic [47:0] stamp;
		logic signed [31:0] pdx, pdy, rdx, rdy;
		logic [30:0] err_dist;
		logic last;
	} retire_t;

	typedef struct {
		logic [47:0] stamp;
		longint x, y;
		logic [15:0] heading;
		longint px, py;
	} queued_t;

	typedef struct {
		sample_t s;
		int rep;
		bit typed;
		retire_t res;
	} row_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser;
	logic [dwec_pkg::IN_DATA_W-1:0] s_tdata;
	logic m_tvalid, m_tready, m_tlast;
	logic [dwec_pkg::OUT_DATA_W-1:0] m_tdata;
	logic cfg_we;
	logic [dwec_pkg::HOR_W-1:0] cfg_wdata;

	retire_t exp_mem[EXP_DEPTH];
	int exp_wr, exp_rd;
	queued_t waypoint_store[DEPTH];
	int head_idx, entry_cnt;
	logic [47:0] pose_stamp;
	longint pose_x, pose_y;
	logic [15:0] pose_heading;
	bit pose_ok;
	logic [dwec_pkg::HOR_W-1:0] horizon;
	int failures, idle_cycles;
	logic [15:0] angle_tab[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1, 0};

	delayed_waypoint_error_checker dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	task automatic queue_expected(input retire_t r);
		exp_mem[exp_wr % EXP_DEPTH] = r;
		exp_wr++;
	endtask

	function automatic logic [15:0] heading_of(longint w, longint x, longint y, longint z);
		longint n, d, nd;
		int ang;
		n = 2 * (w * z + x * y);
		d = (longint'(1) << 28) - 2 * (y * y + z * z);
		ang = 0;
		if (n == 0 && d == 0)
			return 16'd0;
		if (d < 0) begin
			d = -d;
			n = -n;
			ang = 'h8000;
		end
		for (int i = 0; i < 16; i++) begin
			if (n > 0) begin
				nd = d + (n >>> i);
				n = n - (d >>> i);
				ang += angle_tab[i];
			end else begin
				nd = d - (n >>> i);
				n = n + (d >>> i);
				ang -= angle_tab[i];
			end
			d = nd;
		end
		return ang[15:0];
	endfunction

	task automatic cos_sin_of(input logic [15:0] h, output longint c, output longint s);
		int a;
		bit flip;
		longint x, y, nx;
		a = int'(h);
		flip = 0;
		x = longint'(dwec_pkg::CORDIC_K);
		y = 0;
		if (a >= 32768) a -= 65536;
		if (a > 16384) begin
			a -= 32768;
			flip = 1;
		end else if (a < -16384) begin
			a += 32768;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			if (a >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				a -= angle_tab[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				a += angle_tab[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [30:0] error_len(longint ex, longint ey);
		longint unsigned r;
		if (ex >= 64'sd2147483648 || ex <= -64'sd2147483648 ||
			ey >= 64'sd2147483648 || ey <= -64'sd2147483648)
			return 31'h7FFFFFFF;
		r = int_sqrt(longint'(ex * ex) + longint'(ey * ey));
		return (r > 64'd2147483647) ? 31'h7FFFFFFF : r[30:0];
	endfunction

	task automatic predict_item(input sample_t t, input bit keep);
		queued_t e;
		retire_t r;
		longint c, s, dx, dy, rx, ry;
		if (t.op == OP_WAYPOINT) begin
			if (!pose_ok || entry_cnt >= DEPTH) return;
			e.stamp = t.stamp;
			e.x = pose_x;
			e.y = pose_y;
			e.heading = pose_heading;
			e.px = t.pred_x;
			e.py = t.pred_y;
			waypoint_store[(head_idx + entry_cnt) % DEPTH] = e;
			entry_cnt++;
			return;
		end
		if (pose_ok && t.stamp < pose_stamp) begin
			entry_cnt = 0;
			head_idx = 0;
		end
		pose_stamp = t.stamp;
		pose_x = t.pos_x;
		pose_y = t.pos_y;
		pose_heading = heading_of(t.qw, t.qx, t.qy, t.qz);
		pose_ok = 1;
		while (entry_cnt > 0) begin
			e = waypoint_store[head_idx];
			if ({16'd0, t.stamp} < {16'd0, e.stamp} + 64'(horizon)) break;
			cos_sin_of(e.heading, c, s);
			dx = pose_x - e.x;
			dy = pose_y - e.y;
			rx = (c * dx + s * dy + (longint'(1) << 29)) >>> 30;
			ry = (c * dy - s * dx + (longint'(1) << 29)) >>> 30;
			r.stamp = e.stamp;
			r.pdx = e.px[31:0];
			r.pdy = e.py[31:0];
			r.rdx = clamp32(rx);
			r.rdy = clamp32(ry);
			r.err_dist = error_len(e.px - rx, e.py - ry);
			r.last = (entry_cnt == 1) || ({16'd0, t.stamp} <
				{16'd0, waypoint_store[(head_idx + 1) % DEPTH].stamp} + 64'(horizon));
			if (keep) queue_expected(r);
			head_idx = (head_idx + 1) % DEPTH;
			entry_cnt--;
		end
	endtask

	task automatic send(input sample_t t);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= t.op;
		s_tdata <= {t.pred_y, t.pred_x, t.qz, t.qy, t.qx, t.qw, t.pos_y, t.pos_x, t.stamp};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic set_horizon(input logic [dwec_pkg::HOR_W-1:0] v);
		s_tvalid <= 1'b0;
		wait (exp_wr == exp_rd);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		horizon = v;
	endtask

	function automatic logic signed [15:0] rand_quat();
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	task automatic random_phase(input logic [dwec_pkg::HOR_W-1:0] h, input int count,
		inout logic [47:0] now);
		sample_t t;
		int sent;
		sent = 0;
		set_horizon(h);
		while (sent < count) begin
			t.op = ($urandom_range(0, 9) < 5) ? OP_WAYPOINT : OP_ODOM;
			if ($urandom_range(0, 15) == 0) begin
				int burst;
				burst = $urandom_range(10, 20);
				for (int b = 0; b < burst; b++) begin
					t.op = OP_WAYPOINT;
					t.stamp = 48'(now + 48'(b));
					t.pred_x = $urandom;
					t.pred_y = $urandom;
					send(t);
					predict_item(t, 1);
				end
				now = 48'(now + 48'(burst));
				sent += burst;
				continue;
			end
			case ($urandom_range(0, 19))
				0: now = 48'({$urandom, $urandom});
				1: now = now / 2;
				default: now = 48'(now + 48'($urandom_range(0, h / 2 + 2)));
			endcase
			t.stamp = now;
			if ($urandom_range(0, 4) == 0) begin
				t.pos_x = $urandom;
				t.pos_y = $urandom;
			end else begin
				t.pos_x = 32'(pose_x + longint'($signed(20'($urandom))));
				t.pos_y = 32'(pose_y + longint'($signed(20'($urandom))));
			end
			t.qw = rand_quat();
			t.qx = rand_quat();
			t.qy = rand_quat();
			t.qz = rand_quat();
			if ($urandom_range(0, 3) == 0) begin
				t.pred_x = $urandom;
				t.pred_y = $urandom;
			end else begin
				t.pred_x = 32'($signed(20'($urandom)));
				t.pred_y = 32'($signed(20'($urandom)));
			end
			send(t);
			predict_item(t, 1);
			sent++;
		end
	endtask

	initial begin
		int calm;
		int w;
		m_tready = 1'b0;
		calm = 0;
		forever begin
			@(negedge clk);
			if (calm > 0)
				calm--;
			else begin
				if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 30);
				w = $urandom_range(0, 7);
				if (w > 0) begin
					m_tready <= 1'b0;
					repeat (w) @(negedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		retire_t exp_r;
		if (m_tvalid && m_tready) begin
			if (exp_wr == exp_rd) begin
				$error("unexpected result transaction, stamp %0d", m_tdata[47:0]);
				failures++;
			end else begin
				exp_r = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (m_tdata[47:0] !== exp_r.stamp) begin
					$error("entry_stamp exp %0d got %0d", exp_r.stamp, m_tdata[47:0]);
					failures++;
				end
				if (m_tdata[79:48] !== exp_r.pdx) begin
					$error("predicted_dx exp %0d got %0d", exp_r.pdx, $signed(m_tdata[79:48]));
					failures++;
				end
				if (m_tdata[111:80] !== exp_r.pdy) begin
					$error("predicted_dy exp %0d got %0d", exp_r.pdy, $signed(m_tdata[111:80]));
					failures++;
				end
				if (m_tdata[143:112] !== exp_r.rdx) begin
					$error("recorded_dx exp %0d got %0d", exp_r.rdx, $signed(m_tdata[143:112]));
					failures++;
				end
				if (m_tdata[175:144] !== exp_r.rdy) begin
					$error("recorded_dy exp %0d got %0d", exp_r.rdy, $signed(m_tdata[175:144]));
					failures++;
				end
				if (m_tdata[206:176] !== exp_r.err_dist) begin
					$error("error_distance exp %0d got %0d", exp_r.err_dist, m_tdata[206:176]);
					failures++;
				end
				if (m_tlast !== exp_r.last) begin
					$error("last exp %0d got %0d", exp_r.last, m_tlast);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		row_t rows[MAX_ROWS];
		int n_rows;
		row_t rw;
		sample_t t;
		logic [47:0] now;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		failures = 0;
		idle_cycles = 0;
		exp_wr = 0;
		exp_rd = 0;
		head_idx = 0;
		entry_cnt = 0;
		pose_stamp = 0;
		pose_x = 0;
		pose_y = 0;
		pose_heading = 0;
		pose_ok = 0;
		horizon = dwec_pkg::HORIZON_RESET;
		n_rows = 0;

		rw = '{s: '{OP_WAYPOINT, 48'd5, 0, 0, 0, 0, 0, 0, 32'sd7, 32'sd9},
			rep: 1, typed: 0, res: '{default: 0}};
		rows[n_rows] = rw; n_rows++;
		rw.s = '{OP_ODOM, 48'd0, 0, 0, 16'sd16384, 0, 0, 0, 0, 0};
		rows[n_rows] = rw; n_rows++;
		rw.s = '{OP_WAYPOINT, 48'd0, 32'sd55, 32'sd66, 0, 0, 0, 0, 0, 0};
		rows[n_rows] = rw; n_rows++;
		rw.s = '{OP_ODOM, 48'd1000000, 0, 0, 16'sd16384, 0, 0, 0, 0, 0};
		rw.typed = 1;
		rw.res = '{stamp: 48'd0, pdx: 0, pdy: 0, rdx: 0, rdy: 0, err_dist: 0, last: 1'b1};
		rows[n_rows] = rw; n_rows++;
		rw.typed = 0;
		// zero yaw vector
		rw.s = '{OP_ODOM, 48'd2000000, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 16'sd8192,
			16'sd8192, 0, 0};
		rows[n_rows] = rw; n_rows++;
		rw.s = '{OP_WAYPOINT, 48'd2000000, 0, 0, 0, 0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000};
		rows[n_rows] = rw; n_rows++;
		rw.s = '{OP_ODOM, 48'd3000000, 32'sh80000000, 32'sh7FFFFFFF, -16'sd16384,
			16'sd16384, -16'sd16384, 16'sd16384, 0, 0};
		rows[n_rows] = rw; n_rows++;
		// fill past capacity
		rw.s = '{OP_WAYPOINT, 48'd3000000, 0, 0, 0, 0, 0, 0, -32'sd12345, 32'sd98765};
		rw.rep = 18;
		rows[n_rows] = rw; n_rows++;
		rw.rep = 1;
		rw.s = '{OP_ODOM, 48'd4000100, 32'sd65536, -32'sd65536, 16'sd11585, 0, 0,
			16'sd11585, 0, 0};
		rows[n_rows] = rw; n_rows++;
		rw.s = '{OP_WAYPOINT, 48'd4000100, 0, 0, 0, 0, 0, 0, 32'sd1, 32'sd2};
		rows[n_rows] = rw; n_rows++;
		// time going back
		rw.s = '{OP_ODOM, 48'd10, 32'sd3, 32'sd4, 0, 16'sd16384, 0, 0, 0, 0};
		rows[n_rows] = rw; n_rows++;
		rw.s = '{OP_ODOM, 48'd5000000, 32'sd5, 32'sd6, 0, 0, 0, 16'sd16384, 0, 0};
		rows[n_rows] = rw; n_rows++;
		rw.s = '{OP_ODOM, 48'hFFFFFFFFFFFF, 32'sd100, 32'sd200, 0, 0, 0, -16'sd16384, 0, 0};
		rows[n_rows] = rw; n_rows++;
		rw.s = '{OP_WAYPOINT, 48'hFFFFFFFFFFFF, 0, 0, 0, 0, 0, 0, -32'sd1, 32'sd1};
		rows[n_rows] = rw; n_rows++;
		rw.s = '{OP_ODOM, 48'hFFFFFFFFFFFF, 32'sd100, 32'sd200, 16'sd16384, 0, 0, 0, 0, 0};
		rows[n_rows] = rw; n_rows++;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < n_rows; i++) begin
			for (int r = 0; r < rows[i].rep; r++) begin
				t = rows[i].s;
				t.stamp = 48'(t.stamp + 48'(r));
				send(t);
				predict_item(t, !rows[i].typed);
				if (rows[i].typed) queue_expected(rows[i].res);
			end
		end

		set_horizon('0);
		t = '{OP_ODOM, 48'hFFFFFFFFFFFF, 32'sd7, 32'sd8, 16'sd16384, 0, 0, 0, 0, 0};
		send(t);
		predict_item(t, 1);

		now = 48'd1000;
		random_phase('0, 10, now);
		random_phase(26'h3FFFFFF, 10, now);
		random_phase(26'd60000000, 10, now);
		random_phase(26'($urandom_range(1, 2000000)), 10, now);
		random_phase(26'($urandom_range(1, 60000000)), 10, now);
		random_phase(26'd1, 10, now);

		s_tvalid <= 1'b0;
		wait (exp_wr == exp_rd);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && exp_wr == exp_rd)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
